// ===== hw/rtl/mat3_inverse_core_defines.svh =====
// Assertion macros shared by the 3x3 inverse RTL.
`ifndef MAT3_INVERSE_CORE_DEFINES_SVH
`define MAT3_INVERSE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, off during reset.
`define M3INV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("m3inv implication failed");
// Delayed implication on clk, off during reset.
`define M3INV_ASSERT_LAT(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("m3inv latency check failed");
`else
`define M3INV_ASSERT_IMP(lbl, ante, cons)
`define M3INV_ASSERT_LAT(lbl, ante, n, cons)
`endif

`endif

// ===== hw/rtl/m3inv_pkg.sv =====
// Types and constants of the 3x3 fixed-point matrix inverse.
package m3inv_pkg;

	localparam int EW        = 32;            // element width
	localparam int FRAC_BITS = 16;            // fraction bits of Q16.16
	localparam int PW        = 2 * EW;        // product of two elements
	localparam int CW        = PW + 1;        // cofactor
	localparam int DETW      = CW + EW + 2;   // determinant, signed
	localparam int RW        = DETW + 1;      // divider remainder
	localparam int DIV_STEPS = 2 * FRAC_BITS; // quotient bits, equals EW here
	localparam int LATENCY   = 9 + DIV_STEPS; // accept to result strobe

	localparam logic [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

	typedef logic signed [EW-1:0]   elem_t;
	typedef logic signed [PW-1:0]   prod_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic signed [DETW-1:0] detw_t;

	typedef struct packed {
		elem_t in_r0c0; elem_t in_r0c1; elem_t in_r0c2;
		elem_t in_r1c0; elem_t in_r1c1; elem_t in_r1c2;
		elem_t in_r2c0; elem_t in_r2c1; elem_t in_r2c2;
	} req_t;

	typedef struct packed {
		elem_t out_r0c0; elem_t out_r0c1; elem_t out_r0c2;
		elem_t out_r1c0; elem_t out_r1c1; elem_t out_r1c2;
		elem_t out_r2c0; elem_t out_r2c1; elem_t out_r2c2;
		logic  singular;
		logic  clipped;
	} rsp_t;

	// determinant as the divider lanes see it
	typedef struct packed {
		logic            vld;
		logic            neg;
		logic            zero;
		logic [DETW-1:0] mag;
	} det_t;

endpackage

// ===== hw/rtl/m3inv_cof.sv =====
// Cofactor stages: eighteen products, then the nine cross-product terms.
module m3inv_cof import m3inv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  req_t  req,
	output logic  vld_s2,
	output cof_t  cof_s2 [9],
	output elem_t c2_s2 [3]
);

	elem_t e [3][3];
	prod_t pa_d [9];
	prod_t pb_d [9];
	prod_t pa_s1 [9];
	prod_t pb_s1 [9];
	elem_t c2_s1 [3];
	logic  vld_s1;

	assign e[0][0] = req.in_r0c0; assign e[0][1] = req.in_r0c1; assign e[0][2] = req.in_r0c2;
	assign e[1][0] = req.in_r1c0; assign e[1][1] = req.in_r1c1; assign e[1][2] = req.in_r1c2;
	assign e[2][0] = req.in_r2c0; assign e[2][1] = req.in_r2c1; assign e[2][2] = req.in_r2c2;

	// row i is col(i+1) x col(i+2); component k
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				pa_d[i*3+k] = prod_t'(e[(k+1)%3][(i+1)%3]) * prod_t'(e[(k+2)%3][(i+2)%3]);
				pb_d[i*3+k] = prod_t'(e[(k+2)%3][(i+1)%3]) * prod_t'(e[(k+1)%3][(i+2)%3]);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		for (int n = 0; n < 9; n++) begin
			pa_s1[n]  <= pa_d[n];
			pb_s1[n]  <= pb_d[n];
			cof_s2[n] <= cof_t'(pa_s1[n]) - cof_t'(pb_s1[n]);
		end
		for (int k = 0; k < 3; k++) begin
			c2_s1[k] <= e[k][2];
			c2_s2[k] <= c2_s1[k];
		end
	end

endmodule

// ===== hw/rtl/m3inv_det.sv =====
// Determinant stages: dot of the last cofactor row with column 2, then magnitude.
module m3inv_det import m3inv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld_s2,
	input  cof_t  cof_s2 [9],
	input  elem_t c2_s2 [3],
	output det_t  det_s6,
	output cof_t  cof_s6 [9]
);

	cof_t  lo_s3 [3];
	cof_t  hi_s3 [3];
	detw_t prod_s4 [3];
	detw_t det_s5;
	cof_t  cof_s3 [9];
	cof_t  cof_s4 [9];
	cof_t  cof_s5 [9];
	logic  vld_s3, vld_s4, vld_s5;
	logic  vld_s6, neg_s6, zero_s6;
	logic  [DETW-1:0] mag_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		// 65x32 split into two ~33x32 partial products
		for (int k = 0; k < 3; k++) begin
			lo_s3[k] <= cof_t'($signed({1'b0, cof_s2[6+k][EW-1:0]})) * cof_t'(c2_s2[k]);
			hi_s3[k] <= cof_t'($signed(cof_s2[6+k][CW-1:EW])) * cof_t'(c2_s2[k]);
		end
		// recombine partial products
		for (int k = 0; k < 3; k++)
			prod_s4[k] <= detw_t'($signed({hi_s3[k], {EW{1'b0}}})) + detw_t'(lo_s3[k]);
		det_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
		// sign, zero test and magnitude for the divider
		neg_s6  <= det_s5[DETW-1];
		zero_s6 <= (det_s5 == '0);
		mag_s6  <= det_s5[DETW-1] ? DETW'(-det_s5) : DETW'(det_s5);
		for (int n = 0; n < 9; n++) begin
			cof_s3[n] <= cof_s2[n];
			cof_s4[n] <= cof_s3[n];
			cof_s5[n] <= cof_s4[n];
			cof_s6[n] <= cof_s5[n];
		end
	end

	assign det_s6 = '{vld: vld_s6, neg: neg_s6, zero: zero_s6, mag: mag_s6};

endmodule

// ===== hw/rtl/m3inv_div.sv =====
// Nine pipelined restoring dividers, one quotient bit per stage, then saturation.
module m3inv_div import m3inv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  det_t det_s6,
	input  cof_t cof_s6 [9],
	output logic vld_out,
	output rsp_t rsp_out
);

	// magnitude stage
	logic [CW-1:0]   acof_s7 [9];
	logic            sgn_s7 [9];
	logic [DETW-1:0] d_s7;
	logic            zero_s7, vld_s7;

	// divider stages, index 0 is the setup stage
	logic [RW-1:0]   rem_s  [DIV_STEPS+1][9];
	logic [EW-1:0]   quo_s  [DIV_STEPS+1][9];
	logic            sgn_s  [DIV_STEPS+1][9];
	logic            ovf_s  [DIV_STEPS+1][9];
	logic [DETW-1:0] d_s    [DIV_STEPS+1];
	logic            zero_s [DIV_STEPS+1];
	logic            vld_s  [DIV_STEPS+1];

	logic [EW-1:0]   val_d [9];
	logic            clip_d;
	rsp_t            out_d;
	rsp_t            out_s41;
	logic            vld_s41;

	// magnitude of each cofactor, sign of each quotient
	always_ff @(posedge clk) begin
		for (int n = 0; n < 9; n++) begin
			acof_s7[n] <= cof_s6[n][CW-1] ? CW'(-cof_s6[n]) : CW'(cof_s6[n]);
			sgn_s7[n]  <= cof_s6[n][CW-1] ^ det_s6.neg;
		end
		d_s7    <= det_s6.mag;
		zero_s7 <= det_s6.zero;
	end

	// setup: quotient overflows the element range when |cof| >= |det|
	always_ff @(posedge clk) begin
		for (int n = 0; n < 9; n++) begin
			rem_s[0][n] <= RW'(acof_s7[n]);
			quo_s[0][n] <= '0;
			sgn_s[0][n] <= sgn_s7[n];
			ovf_s[0][n] <= ({{(DETW-CW){1'b0}}, acof_s7[n]} >= d_s7);
		end
		d_s[0]    <= d_s7;
		zero_s[0] <= zero_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s7   <= det_s6.vld;
			vld_s[0] <= vld_s7;
		end
	end

	// one quotient bit per stage
	for (genvar t = 0; t < DIV_STEPS; t++) begin : g_step
		logic [RW-1:0] sh [9];
		logic [RW:0]   df [9];

		always_comb begin
			for (int n = 0; n < 9; n++) begin
				sh[n] = {rem_s[t][n][RW-2:0], 1'b0};
				df[n] = {1'b0, sh[n]} - {2'b00, d_s[t]};
			end
		end

		always_ff @(posedge clk) begin
			for (int n = 0; n < 9; n++) begin
				rem_s[t+1][n] <= df[n][RW] ? sh[n] : df[n][RW-1:0];
				quo_s[t+1][n] <= {quo_s[t][n][EW-2:0], ~df[n][RW]};
				sgn_s[t+1][n] <= sgn_s[t][n];
				ovf_s[t+1][n] <= ovf_s[t][n];
			end
			d_s[t+1]    <= d_s[t];
			zero_s[t+1] <= zero_s[t];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t+1] <= 1'b0;
			end else begin
				vld_s[t+1] <= vld_s[t];
			end
		end
	end

	// saturate, apply sign, zero everything on a singular matrix
	always_comb begin
		clip_d = 1'b0;
		for (int n = 0; n < 9; n++) begin
			if (zero_s[DIV_STEPS]) begin
				val_d[n] = '0;
			end else if (ovf_s[DIV_STEPS][n] ||
				(sgn_s[DIV_STEPS][n] ? (quo_s[DIV_STEPS][n] > EMIN)
					: quo_s[DIV_STEPS][n][EW-1])) begin
				val_d[n] = sgn_s[DIV_STEPS][n] ? EMIN : EMAX;
				clip_d   = 1'b1;
			end else begin
				val_d[n] = sgn_s[DIV_STEPS][n] ? (~quo_s[DIV_STEPS][n] + 1'b1)
					: quo_s[DIV_STEPS][n];
			end
		end
		out_d.out_r0c0 = val_d[0]; out_d.out_r0c1 = val_d[1]; out_d.out_r0c2 = val_d[2];
		out_d.out_r1c0 = val_d[3]; out_d.out_r1c1 = val_d[4]; out_d.out_r1c2 = val_d[5];
		out_d.out_r2c0 = val_d[6]; out_d.out_r2c1 = val_d[7]; out_d.out_r2c2 = val_d[8];
		out_d.singular = zero_s[DIV_STEPS];
		out_d.clipped  = clip_d;
	end

	always_ff @(posedge clk) begin
		out_s41 <= out_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s41 <= 1'b0;
		end else begin
			vld_s41 <= vld_s[DIV_STEPS];
		end
	end

	assign vld_out = vld_s41;
	assign rsp_out = out_s41;

endmodule

// ===== hw/rtl/mat3_inverse_core.sv =====
// Top level of the pipelined 3x3 Q16.16 matrix inverse.
// Usage:
//   Drive a matrix on req and raise start for one cycle per request. busy is
//   always low, so a request is taken at every edge where start is high, one
//   new matrix per clock cycle.
//   Each result appears on rsp for exactly one cycle with done high, in request
//   order. The path runs through two cofactor stages, four determinant stages,
//   two setup stages, the 32-stage divider (one quotient bit per stage) and the
//   output register.
//   The receiver cannot stall; it must take rsp while done is high.
//   A zero determinant gives all-zero elements with singular set. Elements
//   whose quotient leaves the 32-bit range saturate and set clipped.
//   Reset (arst_n low) clears all valid bits at once: requests in flight are
//   dropped and no done strobe follows until new requests come in.
`include "mat3_inverse_core_defines.svh"

module mat3_inverse_core import m3inv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	logic  vld_s2;
	cof_t  cof_s2 [9];
	elem_t c2_s2 [3];
	det_t  det_s6;
	cof_t  cof_s6 [9];

	// fully pipelined, never holds off a request
	assign busy = 1'b0;

	m3inv_cof u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start & ~busy),
		.req    (req),
		.vld_s2 (vld_s2),
		.cof_s2 (cof_s2),
		.c2_s2  (c2_s2)
	);

	m3inv_det u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s2 (vld_s2),
		.cof_s2 (cof_s2),
		.c2_s2  (c2_s2),
		.det_s6 (det_s6),
		.cof_s6 (cof_s6)
	);

	m3inv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.det_s6  (det_s6),
		.cof_s6  (cof_s6),
		.vld_out (done),
		.rsp_out (rsp)
	);

	// checks
	`M3INV_ASSERT_LAT(a_latency, start, LATENCY, done)
	`M3INV_ASSERT_IMP(a_done_src, done, $past(start, LATENCY))
	`M3INV_ASSERT_IMP(a_singular_zero, done && rsp.singular, !rsp.clipped && rsp.out_r0c0 == '0 && rsp.out_r1c1 == '0 && rsp.out_r2c2 == '0)

endmodule
